[hdl/bpm_pkg.sv]
// Shared types and constants for the battery pack monitor.
// No dependencies; used by the channel interfaces and the top level.
package bpm_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int SAMPLE_FIELDS = 4;
    localparam int SUM_W         = 14;
    localparam int MV_W          = 16;
    localparam int THR_W         = 13;
    localparam int PCT_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int PROD_W        = 28;

    // shared restoring divider
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    // divide by three as multiply and shift, exact below 2^16
    localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
    localparam int          DIV3_SHIFT = 17;

    localparam logic [MV_W-1:0]  DETECT_MIN_MV = 16'd3000;
    localparam logic [THR_W:0]   HYST_MV       = 14'd50;
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADC_SCALE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_MV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROF_LOW_MV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROF_CRIT_MV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUST_LOW_MV   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUST_CRIT_MV  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_CELLS  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SAT,
        ST_DETECT,
        ST_THRESH,
        ST_CELL,
        ST_EVAL,
        ST_PCT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [MV_W-1:0]  pack_mv;
        logic [2:0]       cell_count;
        logic [MV_W-1:0]  cell_mv;
        logic             low_alert;
        logic             critical_alert;
        logic             low_latched;
        logic             critical_latched;
        logic             below_low;
        logic             below_critical;
        logic [PCT_W-1:0] charge_percent;
        logic             battery_present;
    } result_t;

endpackage

[hdl/bpm_channels.sv]
// Valid/ready channel interfaces: measurement requests in, results out.
// Depends on bpm_pkg for field widths.
interface bpm_sample_if;
    import bpm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
    logic                usb_powered;

    modport source (output valid, sample_a, sample_b, sample_c, sample_d, usb_powered,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, usb_powered,
                    output ready);
endinterface

interface bpm_result_if;
    import bpm_pkg::*;
    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  pack_mv;
    logic [2:0]       cell_count;
    logic [MV_W-1:0]  cell_mv;
    logic             low_alert;
    logic             critical_alert;
    logic             low_latched;
    logic             critical_latched;
    logic             below_low;
    logic             below_critical;
    logic [PCT_W-1:0] charge_percent;
    logic             battery_present;

    modport source (output valid, pack_mv, cell_count, cell_mv, low_alert, critical_alert,
                    low_latched, critical_latched, below_low, below_critical,
                    charge_percent, battery_present,
                    input ready);
    modport sink   (input valid, pack_mv, cell_count, cell_mv, low_alert, critical_alert,
                    low_latched, critical_latched, below_low, below_critical,
                    charge_percent, battery_present,
                    output ready);
endinterface

[hdl/battery_pack_monitor.sv]
// Battery pack monitor: averaging, scaling, cell count lock, hysteresis flags, percent.
// Depends on bpm_pkg and the channel interfaces in bpm_channels.sv.
//
// Usage
//   sample_ch carries one measurement request: four raw ADC samples and the
//   USB-power flag. result_ch returns exactly one result per request.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write it
//   only while no request is in flight.
// Throughput
//   One request at a time. The average is a shift (a reciprocal multiply for
//   three samples). A single restoring divider (one quotient bit per cycle)
//   is shared by the cell count lock, the per-cell division and the percent
//   division. A request with no cell count skips all divisions; with a count
//   it runs the per-cell division and, when the percent needs one, the percent
//   division; a reading that locks the count by division runs that one first.
//   sample_ch.ready is high only while idle; it rises with the clock edge
//   that loads each result.
// Reset
//   rst_n (async, active low) restores the register defaults, forgets the
//   cell count, clears both hysteresis flags and empties the output register.
// Stall
//   The result sits in an output register; a new request is taken while it
//   waits. A finished request holds in its last step until that register
//   frees up, so no result is ever dropped or overwritten.
module battery_pack_monitor #(
    parameter int MAX_SERIES_CELLS = 6,
    parameter int SAMPLES_PER_READ = 4,
    parameter int ADC_BITS         = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    bpm_sample_if.sink                      sample_ch,
    bpm_result_if.source                    result_ch
);
    import bpm_pkg::*;

    // cell count width: enough for MAX_SERIES_CELLS and for the 3-bit manual count
    localparam int CW_RAW = $clog2(MAX_SERIES_CELLS + 1);
    localparam int CNT_W  = (CW_RAW < 3) ? 3 : CW_RAW;
    // number of sample fields that take part in the average
    localparam int NSAMP  = (SAMPLES_PER_READ > SAMPLE_FIELDS) ? SAMPLE_FIELDS :
                            ((SAMPLES_PER_READ < 1) ? 1 : SAMPLES_PER_READ);
    // shift for the power-of-two sample counts
    localparam int AVG_SH = (NSAMP == 4) ? 2 : ((NSAMP == 2) ? 1 : 0);

    // ---------------- configuration registers ----------------
    logic [MV_W-1:0]  adc_scale_reg;
    logic [THR_W-1:0] nominal_mv_reg, full_mv_reg, prof_low_reg, prof_crit_reg;
    logic [THR_W-1:0] cust_low_reg, cust_crit_reg;
    logic [2:0]       manual_cells_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_scale_reg    <= 16'd3300;
            nominal_mv_reg   <= 13'd3700;
            full_mv_reg      <= 13'd4200;
            prof_low_reg     <= 13'd3500;
            prof_crit_reg    <= 13'd3300;
            cust_low_reg     <= '0;
            cust_crit_reg    <= '0;
            manual_cells_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADC_SCALE:    adc_scale_reg    <= cfg_wdata;
                REG_NOMINAL_MV:   nominal_mv_reg   <= cfg_wdata[THR_W-1:0];
                REG_FULL_MV:      full_mv_reg      <= cfg_wdata[THR_W-1:0];
                REG_PROF_LOW_MV:  prof_low_reg     <= cfg_wdata[THR_W-1:0];
                REG_PROF_CRIT_MV: prof_crit_reg    <= cfg_wdata[THR_W-1:0];
                REG_CUST_LOW_MV:  cust_low_reg     <= cfg_wdata[THR_W-1:0];
                REG_CUST_CRIT_MV: cust_crit_reg    <= cfg_wdata[THR_W-1:0];
                REG_MANUAL_CELLS: manual_cells_reg <= cfg_wdata[2:0];
                default:          ;
            endcase
        end
    end

    // ---------------- control and datapath registers ----------------
    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]      cells_known_reg, cells_known_next;
    logic                  low_flag_reg, low_flag_next;
    logic                  crit_flag_reg, crit_flag_next;

    // shared divider: quotient register also shifts the numerator in
    logic [DIV_NUM_W-1:0]  quot_reg, quot_next;
    logic [DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [DIV_DEN_W-1:0]  den_reg, den_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [MV_W-1:0]       pack_reg, pack_next;
    logic [CNT_W-1:0]      cells_reg, cells_next;
    logic [MV_W-1:0]       cell_reg, cell_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;
    logic                  low_ev_reg, low_ev_next;
    logic                  crit_ev_reg, crit_ev_next;
    logic                  below_lo_reg, below_lo_next;
    logic                  below_cr_reg, below_cr_next;
    logic                  usb_reg, usb_next;
    result_t               res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            cells_known_reg <= '0;
            low_flag_reg    <= 1'b0;
            crit_flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            cells_known_reg <= cells_known_next;
            low_flag_reg    <= low_flag_next;
            crit_flag_reg   <= crit_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        pack_reg     <= pack_next;
        cells_reg    <= cells_next;
        cell_reg     <= cell_next;
        pct_reg      <= pct_next;
        low_ev_reg   <= low_ev_next;
        crit_ev_reg  <= crit_ev_next;
        below_lo_reg <= below_lo_next;
        below_cr_reg <= below_cr_next;
        usb_reg      <= usb_next;
        res_reg      <= res_next;
    end

    // ---------------- combinational helpers ----------------
    logic [SUM_W-1:0]     sum_in;
    logic [SUM_W+15:0]    avg3_prod;
    logic [SAMPLE_W-1:0]  avg_in;
    logic                 manual;
    logic [THR_W-1:0]     lo_thr, cr_thr;
    logic [DIV_DEN_W:0]   div_trial, div_diff;
    logic                 div_ge;
    logic                 div_last;
    logic [PROD_W-1:0]    scaled;
    logic [MV_W-1:0]      pack_sat;
    logic [MV_W:0]        detect_num;
    logic [CNT_W-1:0]     cells_sel;
    logic [MV_W-1:0]      cell_q;
    logic [THR_W-1:0]     pct_diff;
    logic [DIV_NUM_W-1:0] pct_num;
    logic                 cell_le_lo, cell_le_cr, cell_gt_lo_h, cell_gt_cr_h, cell_ge_full;

    // truncating average: only the first NSAMP fields count
    assign sum_in = SUM_W'(sample_ch.sample_a)
                  + ((NSAMP > 1) ? SUM_W'(sample_ch.sample_b) : SUM_W'(0))
                  + ((NSAMP > 2) ? SUM_W'(sample_ch.sample_c) : SUM_W'(0))
                  + ((NSAMP > 3) ? SUM_W'(sample_ch.sample_d) : SUM_W'(0));
    assign avg3_prod = (SUM_W+16)'(sum_in) * (SUM_W+16)'(DIV3_RECIP);
    assign avg_in    = (NSAMP == 3) ? SAMPLE_W'(avg3_prod >> DIV3_SHIFT)
                                    : SAMPLE_W'(sum_in >> AVG_SH);

    assign manual = (manual_cells_reg != 3'd0)
                 && (CNT_W'(manual_cells_reg) <= CNT_W'(MAX_SERIES_CELLS));
    assign lo_thr = (cust_low_reg  != '0) ? cust_low_reg  : prof_low_reg;
    assign cr_thr = (cust_crit_reg != '0) ? cust_crit_reg : prof_crit_reg;

    // one restoring step per cycle
    assign div_trial = {rem_reg, quot_reg[DIV_NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_last  = cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1);

    assign scaled     = prod_reg >> ADC_BITS;
    assign pack_sat   = (scaled > PROD_W'(16'hFFFF)) ? 16'hFFFF : scaled[MV_W-1:0];
    assign detect_num = {1'b0, pack_sat} + (MV_W+1)'(nominal_mv_reg >> 1);
    assign cells_sel  = manual ? CNT_W'(manual_cells_reg) : cells_known_reg;

    assign cell_q       = quot_reg[MV_W-1:0];
    assign cell_le_lo   = cell_q <= MV_W'(lo_thr);
    assign cell_le_cr   = cell_q <= MV_W'(cr_thr);
    assign cell_gt_lo_h = cell_q > (MV_W'(lo_thr) + MV_W'(HYST_MV));
    assign cell_gt_cr_h = cell_q > (MV_W'(cr_thr) + MV_W'(HYST_MV));
    assign cell_ge_full = cell_q >= MV_W'(full_mv_reg);
    // only used when critical < cell < full, so the difference fits THR_W bits
    assign pct_diff     = cell_q[THR_W-1:0] - cr_thr;
    assign pct_num      = DIV_NUM_W'(pct_diff) * DIV_NUM_W'(PCT_FULL);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !result_ch.ready;
        cells_known_next = cells_known_reg;
        low_flag_next    = low_flag_reg;
        crit_flag_next   = crit_flag_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        cnt_next         = cnt_reg;
        prod_next        = prod_reg;
        pack_next        = pack_reg;
        cells_next       = cells_reg;
        cell_next        = cell_reg;
        pct_next         = pct_reg;
        low_ev_next      = low_ev_reg;
        crit_ev_next     = crit_ev_reg;
        below_lo_next    = below_lo_reg;
        below_cr_next    = below_cr_reg;
        usb_next         = usb_reg;
        res_next         = res_reg;

        // divider iterates in every division state
        if (state_reg == ST_DETECT || state_reg == ST_CELL || state_reg == ST_PCT)
        begin
            rem_next  = div_ge ? div_diff[DIV_DEN_W-1:0] : div_trial[DIV_DEN_W-1:0];
            quot_next = {quot_reg[DIV_NUM_W-2:0], div_ge};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    usb_next      = sample_ch.usb_powered;
                    cell_next     = '0;
                    pct_next      = '0;
                    low_ev_next   = 1'b0;
                    crit_ev_next  = 1'b0;
                    below_lo_next = 1'b0;
                    below_cr_next = 1'b0;
                    quot_next     = DIV_NUM_W'(avg_in);
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                prod_next  = PROD_W'(quot_reg[SAMPLE_W-1:0]) * PROD_W'(adc_scale_reg);
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                pack_next  = pack_sat;
                state_next = ST_THRESH;
                if (!manual && cells_known_reg == '0 && pack_sat >= DETECT_MIN_MV)
                begin
                    if (nominal_mv_reg == '0)
                        cells_known_next = CNT_W'(MAX_SERIES_CELLS);
                    else
                    begin
                        quot_next  = DIV_NUM_W'(detect_num);
                        rem_next   = '0;
                        den_next   = DIV_DEN_W'(nominal_mv_reg);
                        cnt_next   = '0;
                        state_next = ST_DETECT;
                    end
                end
            end
            ST_DETECT:
            begin
                if (div_last)
                    state_next = ST_THRESH;
            end
            ST_THRESH:
            begin
                // a detection that just finished lands here first
                if (!manual && cells_known_reg == '0 && pack_reg >= DETECT_MIN_MV
                    && nominal_mv_reg != '0)
                begin
                    if (quot_reg == '0)
                        cells_known_next = CNT_W'(1);
                    else if (quot_reg > DIV_NUM_W'(MAX_SERIES_CELLS))
                        cells_known_next = CNT_W'(MAX_SERIES_CELLS);
                    else
                        cells_known_next = quot_reg[CNT_W-1:0];
                    state_next = ST_THRESH;
                end
                else
                begin
                    cells_next = cells_sel;
                    if (cells_sel != '0)
                    begin
                        quot_next  = DIV_NUM_W'(pack_reg);
                        rem_next   = '0;
                        den_next   = DIV_DEN_W'(cells_sel);
                        cnt_next   = '0;
                        state_next = ST_CELL;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_CELL:
            begin
                if (div_last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cell_next     = cell_q;
                below_lo_next = cell_le_lo;
                below_cr_next = cell_le_cr;
                if (!low_flag_reg && cell_le_lo)
                begin
                    low_flag_next = 1'b1;
                    low_ev_next   = 1'b1;
                end
                else if (low_flag_reg && cell_gt_lo_h)
                    low_flag_next = 1'b0;
                if (!crit_flag_reg && cell_le_cr)
                begin
                    crit_flag_next = 1'b1;
                    crit_ev_next   = 1'b1;
                end
                else if (crit_flag_reg && cell_gt_cr_h)
                    crit_flag_next = 1'b0;

                if (cell_ge_full)
                begin
                    pct_next   = PCT_FULL;
                    state_next = ST_FINISH;
                end
                else if (cell_le_cr)
                begin
                    pct_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    quot_next  = pct_num;
                    rem_next   = '0;
                    den_next   = DIV_DEN_W'(full_mv_reg - cr_thr);
                    cnt_next   = '0;
                    state_next = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (div_last)
                begin
                    pct_next   = quot_next[PCT_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    res_next.pack_mv          = pack_reg;
                    res_next.cell_count       = cells_reg[2:0];
                    res_next.cell_mv          = cell_reg;
                    res_next.low_alert        = low_ev_reg;
                    res_next.critical_alert   = crit_ev_reg;
                    res_next.low_latched      = low_flag_reg;
                    res_next.critical_latched = crit_flag_reg;
                    res_next.below_low        = below_lo_reg;
                    res_next.below_critical   = below_cr_reg;
                    res_next.charge_percent   = pct_reg;
                    res_next.battery_present  = (pack_reg >= DETECT_MIN_MV)
                                             && !(usb_reg && !manual);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- ports ----------------
    assign sample_ch.ready = (state_reg == ST_IDLE);

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.pack_mv          = res_reg.pack_mv;
    assign result_ch.cell_count       = res_reg.cell_count;
    assign result_ch.cell_mv          = res_reg.cell_mv;
    assign result_ch.low_alert        = res_reg.low_alert;
    assign result_ch.critical_alert   = res_reg.critical_alert;
    assign result_ch.low_latched      = res_reg.low_latched;
    assign result_ch.critical_latched = res_reg.critical_latched;
    assign result_ch.below_low        = res_reg.below_low;
    assign result_ch.below_critical   = res_reg.below_critical;
    assign result_ch.charge_percent   = res_reg.charge_percent;
    assign result_ch.battery_present  = res_reg.battery_present;

endmodule
